### hw/rtl/complex_fir_81_tap_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex FIR filter
// Shorthand for clocked implication checks with a reset disable.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_FIR_81_TAP_ASSERT_SVH
`define COMPLEX_FIR_81_TAP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFIR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// Consequent must hold in the cycle after the antecedent.
`define CFIR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

### hw/rtl/cfir_pkg.sv
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared constants, the coefficient table and the controller/datapath
// interface types of the complex FIR filter.
// ----------------------------------------------------------------------------
package cfir_pkg;

   localparam int ACC_W       = 40;
   localparam int COEF_W      = 16;
   localparam int COEF_COUNT  = 81;
   localparam int COEF_IDX_W  = 7;
   localparam int TAP_IDX_W   = 8;
   localparam int FRAC_BITS   = 15;

   // Register index of the bypass control.
   localparam logic [0:0] REG_BYPASS = 1'b0;

   // Q1.15 coefficients, index 0 applies to the oldest sample of the window.
   localparam logic signed [COEF_W-1:0] COEF_Q15 [COEF_COUNT] = '{
      16'sd8, 16'sd22, 16'sd18, -16'sd16, -16'sd55, -16'sd50, 16'sd11, 16'sd79,
      16'sd81, 16'sd9, -16'sd59, -16'sd53, -16'sd6, -16'sd18, -16'sd94, -16'sd94,
      16'sd93, 16'sd331, 16'sd314, -16'sd66, -16'sd496, -16'sd516, -16'sd64,
      16'sd400, 16'sd415, 16'sd94, -16'sd30, 16'sd225, 16'sd314, -16'sd341,
      -16'sd1335, -16'sd1363, 16'sd289, 16'sd2465, 16'sd2858, 16'sd430,
      -16'sd3021, -16'sd4207, -16'sd1613, 16'sd2674, 16'sd4751, 16'sd2674,
      -16'sd1613, -16'sd4207, -16'sd3021, 16'sd430, 16'sd2858, 16'sd2465,
      16'sd289, -16'sd1363, -16'sd1335, -16'sd341, 16'sd314, 16'sd225,
      -16'sd30, 16'sd94, 16'sd415, 16'sd400, -16'sd64, -16'sd516,
      -16'sd496, -16'sd66, 16'sd314, 16'sd331, 16'sd93, -16'sd94,
      -16'sd94, -16'sd18, -16'sd6, -16'sd53, -16'sd59, 16'sd9,
      16'sd81, 16'sd79, 16'sd11, -16'sd50, -16'sd55, -16'sd16,
      16'sd18, 16'sd22, 16'sd8
   };

   // Taps past the end of the table carry a zero coefficient.
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (idx < TAP_IDX_W'(COEF_COUNT)) begin
         c = COEF_Q15[idx[COEF_IDX_W-1:0]];
      end
      return c;
   endfunction

   typedef struct packed {
      logic load;     // sample transfer accepted, write it and clear accumulators
      logic rd_en;    // read one delay-line slot
      logic finish;   // load the output register
   } cfir_cmd_type;

   typedef struct packed {
      logic out_stall;  // output register holds a result that is not taken
   } cfir_status_type;

endpackage

### hw/rtl/complex_fir_81_tap.sv
// In both filter and bypass mode a new input sample is accepted only after the
// previous result has gone to the output register, since the single
// delay-line read port feeds one shared complex MAC.
// Reset: synchronous; clears the delay line (per-slot valid bits), the write
// pointer and bypass, so the first TAPS-1 results are warm-up.
// ----------------------------------------------------------------------------
// complex_fir_81_tap
// Complex-sample FIR filter with fixed symmetric real coefficients, stream
// input and output channels and an APB-style control register port.
// ----------------------------------------------------------------------------
module complex_fir_81_tap import cfir_pkg::*; #(
   parameter int TAPS = 81,
   parameter int LEAD = 40,
   parameter int SAMPLE_WIDTH = 16,
   localparam int DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int CSR_AW = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,    // sample_re, sample_im, zero pad
   input  logic              req_tlast,    // block_end
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,    // out_re, out_im, zero pad
   output logic              rsp_tlast,    // out_block_end
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int PTR_W = $clog2(TAPS);

   cfir_cmd_type                   cmd;
   cfir_status_type                status;
   logic [PTR_W-1:0]               wr_slot;
   logic [PTR_W-1:0]               rd_slot;
   logic [TAP_IDX_W-1:0]           tap_idx;
   logic                           bypass_ff;
   logic                           csr_wr;
   logic                           csr_hit;
   logic [SAMPLE_WIDTH-1:0]        out_re;
   logic [SAMPLE_WIDTH-1:0]        out_im;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_AW-1:2] == REG_BYPASS);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? 32'(bypass_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (csr_wr && csr_hit) begin
         bypass_ff <= csr_pwdata[0];
      end
   end

   cfir_ctrl #(
      .TAPS (TAPS),
      .LEAD (LEAD)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .bypass    (bypass_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd),
      .wr_slot   (wr_slot),
      .rd_slot   (rd_slot),
      .tap_idx   (tap_idx)
   );

   cfir_datapath #(
      .TAPS         (TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .bypass        (bypass_ff),
      .cmd           (cmd),
      .status        (status),
      .wr_slot       (wr_slot),
      .rd_slot       (rd_slot),
      .tap_idx       (tap_idx),
      .sample_re     (req_tdata[SAMPLE_WIDTH-1:0]),
      .sample_im     (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .block_end     (req_tlast),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_re        (out_re),
      .out_im        (out_im),
      .out_block_end (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'({out_im, out_re});

endmodule

### hw/rtl/cfir_ram.sv
// ----------------------------------------------------------------------------
// cfir_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cfir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 81,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/cfir_datapath.sv
// ----------------------------------------------------------------------------
// cfir_datapath
// Delay-line memory, per-slot valid bits, shared complex MAC with real
// coefficients, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module cfir_datapath import cfir_pkg::*; #(
   parameter int TAPS = 81,
   parameter int SAMPLE_WIDTH = 16,
   localparam int PTR_W = $clog2(TAPS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           bypass,
   input  cfir_cmd_type                   cmd,
   output cfir_status_type                status,
   input  logic [PTR_W-1:0]               wr_slot,
   input  logic [PTR_W-1:0]               rd_slot,
   input  logic [TAP_IDX_W-1:0]           tap_idx,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
   input  logic                           block_end,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [SAMPLE_WIDTH-1:0]        out_re,
   output logic [SAMPLE_WIDTH-1:0]        out_im,
   output logic                           out_block_end
);

   localparam int SMP_W  = 2 * SAMPLE_WIDTH;
   localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
   localparam int RQ_W   = ACC_W + 1 - FRAC_BITS;
   localparam logic signed [RQ_W-1:0] SAT_HI = RQ_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [RQ_W-1:0] SAT_LO = RQ_W'(-(1 << (SAMPLE_WIDTH - 1)));

   logic [SMP_W-1:0]                ram_rd_data;
   logic [TAPS-1:0]                 valid_ff;
   logic                            s1_valid_ff;
   logic                            s1_live_ff;
   logic signed [COEF_W-1:0]        s1_coef_ff;
   logic signed [SAMPLE_WIDTH-1:0]  x_re;
   logic signed [SAMPLE_WIDTH-1:0]  x_im;
   logic                            s2_valid_ff;
   logic signed [PROD_W-1:0]        prod_re_ff;
   logic signed [PROD_W-1:0]        prod_im_ff;
   logic signed [SAMPLE_WIDTH-1:0]  byp_re_ff;
   logic signed [SAMPLE_WIDTH-1:0]  byp_im_ff;
   logic signed [ACC_W-1:0]         acc_re_ff;
   logic signed [ACC_W-1:0]         acc_im_ff;
   logic                            tag_ff;
   logic                            out_valid_ff;
   logic [SAMPLE_WIDTH-1:0]         out_re_ff;
   logic [SAMPLE_WIDTH-1:0]         out_im_ff;
   logic                            out_block_end_ff;

   // Round half up at bit 15, then clamp to the sample range.
   function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]  rsum;
      logic signed [RQ_W-1:0] rq;
      logic [SAMPLE_WIDTH-1:0] res;
      rsum = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
      rq   = rsum[ACC_W:FRAC_BITS];
      if (rq > SAT_HI) begin
         res = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (rq < SAT_LO) begin
         res = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         res = rq[SAMPLE_WIDTH-1:0];
      end
      return res;
   endfunction

   cfir_ram #(
      .WIDTH (SMP_W),
      .DEPTH (TAPS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (wr_slot),
      .wr_data ({sample_im, sample_re}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   // Slots never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.load) begin
         valid_ff[wr_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_live_ff <= valid_ff[rd_slot];
      s1_coef_ff <= coef_at(tap_idx);
   end

   assign x_re = s1_live_ff ? ram_rd_data[SAMPLE_WIDTH-1:0] : '0;
   assign x_im = s1_live_ff ? ram_rd_data[SMP_W-1:SAMPLE_WIDTH] : '0;

   always_ff @(posedge clock) begin
      prod_re_ff <= x_re * s1_coef_ff;
      prod_im_ff <= x_im * s1_coef_ff;
      if (s1_valid_ff) begin
         byp_re_ff <= x_re;
         byp_im_ff <= x_im;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         tag_ff    <= block_end;
      end else if (s2_valid_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(prod_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_re_ff        <= bypass ? byp_re_ff : round_sat(acc_re_ff);
         out_im_ff        <= bypass ? byp_im_ff : round_sat(acc_im_ff);
         out_block_end_ff <= tag_ff;
      end
   end

   assign status.out_stall = out_valid_ff && !out_ready;
   assign out_valid        = out_valid_ff;
   assign out_re           = out_re_ff;
   assign out_im           = out_im_ff;
   assign out_block_end    = out_block_end_ff;

endmodule

### hw/rtl/cfir_ctrl.sv
// ----------------------------------------------------------------------------
// cfir_ctrl
// Sequencer of the filter: accepts a sample, walks the delay line one tap
// per cycle, waits for the MAC pipeline to drain and hands off the result.
// ----------------------------------------------------------------------------
`include "complex_fir_81_tap_assert.svh"

module cfir_ctrl import cfir_pkg::*; #(
   parameter int TAPS = 81,
   parameter int LEAD = 40,
   localparam int PTR_W = $clog2(TAPS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 bypass,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cfir_status_type      status,
   output cfir_cmd_type         cmd,
   output logic [PTR_W-1:0]     wr_slot,
   output logic [PTR_W-1:0]     rd_slot,
   output logic [TAP_IDX_W-1:0] tap_idx
);

   localparam int LEAD_EFF = (LEAD > TAPS - 1) ? TAPS - 1 : LEAD;
   // Slot of the bypass sample relative to the slot just written.
   localparam int BYP_OFF = (LEAD_EFF + 1) % TAPS;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(TAPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [PTR_W-1:0] wp_ff;
   logic [PTR_W-1:0] slot_ff;
   logic [PTR_W-1:0] tap_ff;
   logic             drain_ff;
   logic             run_last;

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_W+1)'(TAPS)) begin
         sum = sum - (PTR_W+1)'(TAPS);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.rd_en  = (state_ff == ST_RUN);
   assign cmd.finish = (state_ff == ST_FINISH) && !status.out_stall;
   assign wr_slot    = wp_ff;
   assign rd_slot    = slot_ff;
   assign tap_idx    = TAP_IDX_W'(tap_ff);
   assign run_last   = bypass || (tap_ff == LAST_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         slot_ff  <= '0;
         tap_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  // The filter walks from the oldest sample, one past the newest.
                  slot_ff  <= bypass ? wrap_add(wp_ff, PTR_W'(BYP_OFF))
                                     : wrap_add(wp_ff, PTR_W'(1));
                  wp_ff    <= wrap_add(wp_ff, PTR_W'(1));
                  tap_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               slot_ff <= wrap_add(slot_ff, PTR_W'(1));
               tap_ff  <= tap_ff + 1'b1;
               if (run_last) begin
                  drain_ff <= 1'b0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // The drain covers the RAM read and the product register.
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!status.out_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `CFIR_ASSERT_NXT(a_load_starts_run, clock, reset, cmd.load, state_ff == ST_RUN)
   `CFIR_ASSERT_IMP(a_slots_in_range, clock, reset, state_ff == ST_RUN, (slot_ff <= LAST_SLOT) && (wp_ff <= LAST_SLOT))
   `CFIR_ASSERT_NXT(a_finish_frees_input, clock, reset, cmd.finish, req_ready)

endmodule
